// File: hdl/rtlpm_pkg.sv
`default_nettype none
package rtlpm_pkg;

  localparam int SLOTS_DEFAULT = 32;

  localparam logic [5:0]  MAX_LEN   = 6'd32;
  localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [31:0] AGE_RESET = 32'd1;
  localparam logic [5:0]  COUNT_SAT = 6'd63;

  localparam logic [3:0] PROTO_NONE   = 4'd0;
  localparam logic [3:0] PROTO_DIRECT = 4'd1;
  localparam logic [3:0] PROTO_STATIC = 4'd2;
  localparam logic [3:0] PROTO_BGP    = 4'd3;
  localparam logic [3:0] PROTO_EIGRP  = 4'd4;
  localparam logic [3:0] PROTO_OSPF   = 4'd5;
  localparam logic [3:0] PROTO_ISIS   = 4'd6;
  localparam logic [3:0] PROTO_RIP    = 4'd7;

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_DEL    = 2'd1,
    FUNC_FLUSH  = 2'd2,
    FUNC_LOOKUP = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MODE_FIND,
    MODE_FLUSH,
    MODE_LOOK,
    MODE_TOUR
  } scan_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_EVAL,
    ST_WRITE,
    ST_TOUR,
    ST_APPLY,
    ST_OUTER,
    ST_LOAD,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [3:0]  proto;
    logic [31:0] gateway;
    logic [7:0]  port;
    logic [31:0] cost;
    logic [31:0] age;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic       capture;
    logic       scan_start;
    scan_mode_e mode;
    logic       write;
    logic       del;
    logic       grp_req;
    logic       grp_rd;
    logic       rd_outer;
    logic       apply;
    logic       outer_clr;
    logic       outer_inc;
    logic       load_out;
    logic       out_err;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  req_ok;
    logic  proto_ok;
    logic  scan_done;
    logic  found;
    logic  free_found;
    logic  outer_end;
    logic  outer_valid;
    logic  out_free;
  } stat_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = '0;
    end else if (len >= MAX_LEN) begin
      m = ALL_ONES;
    end else begin
      m = ~(ALL_ONES >> len);
    end
    return m;
  endfunction

  function automatic logic [7:0] distance_of(input logic [3:0] proto);
    logic [7:0] d;
    case (proto)
      PROTO_DIRECT: d = 8'd0;
      PROTO_STATIC: d = 8'd1;
      PROTO_BGP:    d = 8'd20;
      PROTO_EIGRP:  d = 8'd90;
      PROTO_OSPF:   d = 8'd110;
      PROTO_ISIS:   d = 8'd115;
      PROTO_RIP:    d = 8'd120;
      default:      d = 8'd255;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// File: hdl/route_table_lpm_engine_core.sv
// IPv4 route table with longest-prefix-match lookup, one request at a time.
// Routes live in a SLOTS-deep RAM read one slot per cycle; valid and chosen
// marks are flip-flops cleared by reset, so the table is usable right after
// reset with no clearing pass. A lookup is one scan of the table; an add or a
// delete is a match scan, then re-election of the one affected prefix group;
// a flush is a scan that clears the protocol's routes, then a re-election for
// each route left afterwards (each survivor re-elects its group). Rejected
// requests skip the scans. The single RAM read port makes each scan serial.
// in_stall_o stays high from acceptance until the result is placed in the
// output register; a result waits there while out_stall_i is high.
`default_nettype none
module route_table_lpm_engine_core import rtlpm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] route_prefix_i,
  input  wire logic [5:0]  route_length_i,
  input  wire logic [31:0] gateway_i,
  input  wire logic [7:0]  port_index_i,
  input  wire logic [31:0] route_cost_i,
  input  wire logic [3:0]  source_proto_i,
  input  wire logic [31:0] dest_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic             hit_o,
  output logic      [31:0] hit_gateway_o,
  output logic      [7:0]  hit_port_o,
  output logic      [5:0]  hit_length_o,
  output logic      [31:0] hit_cost_o,
  output logic      [3:0]  hit_proto_o,
  output logic      [5:0]  removed_count_o
);

  cmd_t  cmd;
  stat_t stat;

  rtlpm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  rtlpm_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .route_prefix_i (route_prefix_i),
    .route_length_i (route_length_i),
    .gateway_i      (gateway_i),
    .port_index_i   (port_index_i),
    .route_cost_i   (route_cost_i),
    .source_proto_i (source_proto_i),
    .dest_address_i (dest_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .hit_gateway_o  (hit_gateway_o),
    .hit_port_o     (hit_port_o),
    .hit_length_o   (hit_length_o),
    .hit_cost_o     (hit_cost_o),
    .hit_proto_o    (hit_proto_o),
    .removed_count_o(removed_count_o)
  );

endmodule
`default_nettype wire

// File: hdl/rtlpm_ram.sv
`default_nettype none
module rtlpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

// File: hdl/rtlpm_ctrl.sv
`default_nettype none
module rtlpm_ctrl import rtlpm_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.mode = MODE_FIND;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (stat_i.func)
          FUNC_ADD, FUNC_DEL: begin
            if (stat_i.req_ok) begin
              cmd_o.scan_start = 1'b1;
              cmd_o.mode = MODE_FIND;
              state_d = ST_SCAN;
            end else begin
              state_d = ST_DONE;
            end
          end
          FUNC_FLUSH: begin
            if (stat_i.proto_ok) begin
              cmd_o.scan_start = 1'b1;
              cmd_o.mode = MODE_FLUSH;
              state_d = ST_SCAN;
            end else begin
              state_d = ST_DONE;
            end
          end
          FUNC_LOOKUP: begin
            cmd_o.scan_start = 1'b1;
            cmd_o.mode = MODE_LOOK;
            state_d = ST_SCAN;
          end
        endcase
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          unique case (stat_i.func)
            FUNC_ADD, FUNC_DEL: state_d = ST_EVAL;
            FUNC_FLUSH: begin
              cmd_o.outer_clr = 1'b1;
              state_d = ST_OUTER;
            end
            FUNC_LOOKUP: state_d = ST_DONE;
          endcase
        end
      end
      ST_EVAL: begin
        if (stat_i.func == FUNC_ADD) begin
          if (stat_i.found || stat_i.free_found) begin
            state_d = ST_WRITE;
          end else begin
            state_d = ST_DONE;
          end
        end else if (stat_i.found) begin
          cmd_o.del        = 1'b1;
          cmd_o.grp_req    = 1'b1;
          cmd_o.scan_start = 1'b1;
          cmd_o.mode       = MODE_TOUR;
          state_d = ST_TOUR;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd_o.write      = 1'b1;
        cmd_o.grp_req    = 1'b1;
        cmd_o.scan_start = 1'b1;
        cmd_o.mode       = MODE_TOUR;
        state_d = ST_TOUR;
      end
      ST_TOUR: begin
        if (stat_i.scan_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        if (stat_i.func == FUNC_FLUSH) begin
          cmd_o.outer_inc = 1'b1;
          state_d = ST_OUTER;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_OUTER: begin
        if (stat_i.outer_end) begin
          state_d = ST_DONE;
        end else if (stat_i.outer_valid) begin
          cmd_o.rd_outer = 1'b1;
          state_d = ST_LOAD;
        end else begin
          cmd_o.outer_inc = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.grp_rd     = 1'b1;
        cmd_o.scan_start = 1'b1;
        cmd_o.mode       = MODE_TOUR;
        state_d = ST_TOUR;
      end
      ST_DONE: begin
        // error unless the operation actually went through
        unique case (stat_i.func)
          FUNC_ADD:    cmd_o.out_err = !(stat_i.req_ok &&
                                         (stat_i.found || stat_i.free_found));
          FUNC_DEL:    cmd_o.out_err = !(stat_i.req_ok && stat_i.found);
          FUNC_FLUSH:  cmd_o.out_err = !stat_i.proto_ok;
          FUNC_LOOKUP: cmd_o.out_err = 1'b0;
        endcase
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/rtlpm_dp.sv
`default_nettype none
module rtlpm_dp import rtlpm_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [31:0] route_prefix_i,
  input  wire logic [5:0]  route_length_i,
  input  wire logic [31:0] gateway_i,
  input  wire logic [7:0]  port_index_i,
  input  wire logic [31:0] route_cost_i,
  input  wire logic [3:0]  source_proto_i,
  input  wire logic [31:0] dest_address_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             status_o,
  output logic             hit_o,
  output logic      [31:0] hit_gateway_o,
  output logic      [7:0]  hit_port_o,
  output logic      [5:0]  hit_length_o,
  output logic      [31:0] hit_cost_o,
  output logic      [3:0]  hit_proto_o,
  output logic      [5:0]  removed_count_o
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] LAST_ADDR = CW'(SLOTS - 1);
  localparam logic [CW-1:0] END_ADDR  = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);

  // request
  func_e       func_q;
  logic [31:0] pfx_q, gw_q, cost_q, dst_q;
  logic [5:0]  len_q;
  logic [7:0]  port_q;
  logic [3:0]  proto_q;

  logic [SLOTS-1:0] valid_q, chosen_q, member_q;
  logic [31:0]      age_q;

  // scan
  scan_mode_e  mode_q;
  logic        run_q, rd_v_q;
  logic [CW-1:0] addr_q, outer_q;
  logic [IW-1:0] rd_idx_q;

  logic          found_q, free_q;
  logic [IW-1:0] found_idx_q, free_idx_q;
  logic [31:0]   found_age_q;

  logic          champ_v_q;
  logic [IW-1:0] champ_idx_q;
  logic [71:0]   champ_key_q;

  logic [31:0] grp_pfx_q;
  logic [5:0]  grp_len_q;

  logic        best_v_q;
  logic [31:0] best_gw_q, best_cost_q;
  logic [7:0]  best_port_q;
  logic [5:0]  best_len_q;
  logic [3:0]  best_proto_q;

  logic [5:0]  removed_q;
  logic        out_valid_q;

  slot_t         rd_data, wr_data;
  logic [IW-1:0] raddr, waddr;
  logic          rd_vld, rd_chosen, in_grp;
  logic [71:0]   rd_key;

  assign raddr = cmd_i.rd_outer ? outer_q[IW-1:0] : addr_q[IW-1:0];
  assign waddr = found_q ? found_idx_q : free_idx_q;

  always_comb begin
    wr_data.prefix  = pfx_q;
    wr_data.len     = len_q;
    wr_data.proto   = proto_q;
    wr_data.gateway = gw_q;
    wr_data.port    = port_q;
    wr_data.cost    = cost_q;
    wr_data.age     = found_q ? found_age_q : age_q;
  end

  rtlpm_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(waddr),
    .wdata_i(wr_data),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  assign rd_vld    = rd_v_q && valid_q[rd_idx_q];
  assign rd_chosen = chosen_q[rd_idx_q];
  assign in_grp    = (rd_data.prefix == grp_pfx_q) && (rd_data.len == grp_len_q);
  assign rd_key    = {distance_of(rd_data.proto), rd_data.cost, rd_data.age};

  // request capture and per-slot scan work
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_e'(func_i);
      pfx_q   <= route_prefix_i & len_mask(route_length_i);
      len_q   <= route_length_i;
      gw_q    <= gateway_i;
      port_q  <= port_index_i;
      cost_q  <= route_cost_i;
      proto_q <= source_proto_i;
      dst_q   <= dest_address_i;
    end
    if (cmd_i.scan_start) begin
      mode_q <= cmd_i.mode;
    end
    rd_idx_q <= addr_q[IW-1:0];
    if (cmd_i.grp_req) begin
      grp_pfx_q <= pfx_q;
      grp_len_q <= len_q;
    end else if (cmd_i.grp_rd) begin
      grp_pfx_q <= rd_data.prefix;
      grp_len_q <= rd_data.len;
    end
    if (rd_vld) begin
      unique case (mode_q)
        MODE_FIND: begin
          if (!found_q && rd_data.prefix == pfx_q && rd_data.len == len_q &&
              rd_data.proto == proto_q) begin
            found_idx_q <= rd_idx_q;
            found_age_q <= rd_data.age;
          end
        end
        MODE_LOOK: begin
          if (rd_chosen && (dst_q & len_mask(rd_data.len)) == rd_data.prefix &&
              (!best_v_q || rd_data.len > best_len_q)) begin
            best_gw_q    <= rd_data.gateway;
            best_port_q  <= rd_data.port;
            best_len_q   <= rd_data.len;
            best_cost_q  <= rd_data.cost;
            best_proto_q <= rd_data.proto;
          end
        end
        MODE_TOUR: begin
          if (in_grp && (!champ_v_q || rd_key < champ_key_q)) begin
            champ_idx_q <= rd_idx_q;
            champ_key_q <= rd_key;
          end
        end
        MODE_FLUSH: ;
      endcase
    end
    if (rd_v_q && !valid_q[rd_idx_q] && !free_q && mode_q == MODE_FIND) begin
      free_idx_q <= rd_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      chosen_q    <= '0;
      member_q    <= '0;
      age_q       <= AGE_RESET;
      run_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      addr_q      <= '0;
      outer_q     <= '0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      champ_v_q   <= 1'b0;
      best_v_q    <= 1'b0;
      removed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q <= run_q;
      if (cmd_i.scan_start) begin
        run_q  <= 1'b1;
        addr_q <= '0;
        // FIND results stay live through the write and reselection
        if (cmd_i.mode == MODE_FIND) begin
          found_q <= 1'b0;
          free_q  <= 1'b0;
        end
        champ_v_q <= 1'b0;
        member_q  <= '0;
        if (cmd_i.mode == MODE_LOOK) begin
          best_v_q <= 1'b0;
        end
      end else if (run_q) begin
        addr_q <= addr_q + 1'b1;
        if (addr_q == LAST_ADDR) begin
          run_q <= 1'b0;
        end
      end
      if (cmd_i.capture) begin
        removed_q <= '0;
      end
      if (rd_v_q && !valid_q[rd_idx_q] && mode_q == MODE_FIND) begin
        free_q <= 1'b1;
      end
      if (rd_vld) begin
        unique case (mode_q)
          MODE_FIND: begin
            if (rd_data.prefix == pfx_q && rd_data.len == len_q &&
                rd_data.proto == proto_q) begin
              found_q <= 1'b1;
            end
          end
          MODE_FLUSH: begin
            if (rd_data.proto == proto_q) begin
              valid_q[rd_idx_q]  <= 1'b0;
              chosen_q[rd_idx_q] <= 1'b0;
              if (removed_q != COUNT_SAT) begin
                removed_q <= removed_q + 6'd1;
              end
            end
          end
          MODE_LOOK: begin
            if (rd_chosen && (dst_q & len_mask(rd_data.len)) == rd_data.prefix &&
                (!best_v_q || rd_data.len > best_len_q)) begin
              best_v_q <= 1'b1;
            end
          end
          MODE_TOUR: begin
            if (in_grp) begin
              member_q[rd_idx_q] <= 1'b1;
              if (!champ_v_q || rd_key < champ_key_q) begin
                champ_v_q <= 1'b1;
              end
            end
          end
        endcase
      end
      if (cmd_i.write && !found_q) begin
        valid_q[free_idx_q] <= 1'b1;
        age_q <= age_q + 32'd1;
      end
      if (cmd_i.del) begin
        valid_q[found_idx_q]  <= 1'b0;
        chosen_q[found_idx_q] <= 1'b0;
      end
      if (cmd_i.apply) begin
        chosen_q <= (chosen_q & ~member_q) |
                    (champ_v_q ? (SLOTS'(1) << champ_idx_q) : '0);
      end
      if (cmd_i.outer_clr) begin
        outer_q <= '0;
      end else if (cmd_i.outer_inc) begin
        outer_q <= outer_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (func_q == FUNC_LOOKUP) begin
        status_o        <= !best_v_q;
        hit_o           <= best_v_q;
        hit_gateway_o   <= best_v_q ? best_gw_q : '0;
        hit_port_o      <= best_v_q ? best_port_q : '0;
        hit_length_o    <= best_v_q ? best_len_q : '0;
        hit_cost_o      <= best_v_q ? best_cost_q : '0;
        hit_proto_o     <= best_v_q ? best_proto_q : '0;
      end else begin
        status_o        <= cmd_i.out_err;
        hit_o           <= 1'b0;
        hit_gateway_o   <= '0;
        hit_port_o      <= '0;
        hit_length_o    <= '0;
        hit_cost_o      <= '0;
        hit_proto_o     <= '0;
      end
      removed_count_o <= (func_q == FUNC_FLUSH) ? removed_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    stat_o.func        = func_q;
    stat_o.req_ok      = (len_q <= MAX_LEN) && (proto_q != PROTO_NONE);
    stat_o.proto_ok    = (proto_q != PROTO_NONE);
    stat_o.scan_done   = rd_v_q && (rd_idx_q == LAST_IDX);
    stat_o.found       = found_q;
    stat_o.free_found  = free_q;
    stat_o.outer_end   = (outer_q == END_ADDR);
    stat_o.outer_valid = valid_q[outer_q[IW-1:0]];
    stat_o.out_free    = !out_valid_q || !out_stall_i;
  end

  chosen_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (chosen_q & ~valid_q) == '0)
    else $error("chosen mark on an empty slot");

  one_winner_per_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply |=> $countones(chosen_q & member_q) <= 1)
    else $error("more than one chosen route in a group");

  write_del_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.write && cmd_i.del))
    else $error("write and delete in the same cycle");

  result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_i.load_out)
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// File: verif/route_table_lpm_engine_core_tb.sv
`default_nettype none
module route_table_lpm_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rtlpm_pkg::*;

  localparam int NSLOT = 32;
  localparam int RANDOM_REQS = 2000;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [31:0] gw;
    logic [7:0]  port;
    logic [31:0] cost;
    logic [3:0]  proto;
    logic [31:0] dst;
  } req_t;

  typedef struct packed {
    logic        status;
    logic        hit;
    logic [31:0] gw;
    logic [7:0]  port;
    logic [5:0]  len;
    logic [31:0] cost;
    logic [3:0]  proto;
    logic [5:0]  removed;
  } resp_t;

  typedef struct packed {
    req_t  req;
    logic  known;
    resp_t resp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic [31:0] route_prefix_i = '0;
  logic [5:0] route_length_i = '0;
  logic [31:0] gateway_i = '0;
  logic [7:0] port_index_i = '0;
  logic [31:0] route_cost_i = '0;
  logic [3:0] source_proto_i = '0;
  logic [31:0] dest_address_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic status_o, hit_o;
  logic [31:0] hit_gateway_o, hit_cost_o;
  logic [7:0] hit_port_o;
  logic [5:0] hit_length_o, removed_count_o;
  logic [3:0] hit_proto_o;

  route_table_lpm_engine_core DUT (.*);

  always #10 clk_i = ~clk_i;

  // shadow route table
  logic        t_valid [NSLOT];
  logic        t_chosen[NSLOT];
  logic [31:0] t_prefix[NSLOT];
  logic [5:0]  t_len   [NSLOT];
  logic [3:0]  t_proto [NSLOT];
  logic [31:0] t_gw    [NSLOT];
  logic [7:0]  t_port  [NSLOT];
  logic [31:0] t_cost  [NSLOT];
  logic [31:0] t_age   [NSLOT];
  logic [31:0] next_age;

  resp_t expected_resps[$];
  int errors = 0;
  int send_idle = 0, recv_idle = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  longint cycles = 0;

  function automatic logic [31:0] prefix_mask(input logic [5:0] l);
    if (l == 0) return '0;
    if (l >= 6'd32) return 32'hFFFF_FFFF;
    return 32'hFFFF_FFFF << (32 - l);
  endfunction

  function automatic logic [7:0] admin_dist(input logic [3:0] p);
    case (p)
      PROTO_DIRECT: return 8'd0;
      PROTO_STATIC: return 8'd1;
      PROTO_BGP:    return 8'd20;
      PROTO_EIGRP:  return 8'd90;
      PROTO_OSPF:   return 8'd110;
      PROTO_ISIS:   return 8'd115;
      PROTO_RIP:    return 8'd120;
      default:      return 8'd255;
    endcase
  endfunction

  function automatic bit better_route(input int a, input int b);
    if (admin_dist(t_proto[a]) != admin_dist(t_proto[b]))
      return admin_dist(t_proto[a]) < admin_dist(t_proto[b]);
    if (t_cost[a] != t_cost[b]) return t_cost[a] < t_cost[b];
    return t_age[a] < t_age[b];
  endfunction

  function automatic void elect_routes();
    for (int i = 0; i < NSLOT; i++) t_chosen[i] = 0;
    for (int i = 0; i < NSLOT; i++) begin
      bit found;
      found = 0;
      if (!t_valid[i]) continue;
      for (int k = 0; k < i; k++) begin
        if (t_valid[k] && t_chosen[k] && t_prefix[k] == t_prefix[i] &&
            t_len[k] == t_len[i]) begin
          found = 1;
          if (better_route(i, k)) begin
            t_chosen[k] = 0;
            t_chosen[i] = 1;
          end
          break;
        end
      end
      if (!found) t_chosen[i] = 1;
    end
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      t_valid[i] = 0; t_chosen[i] = 0; t_prefix[i] = 0; t_len[i] = 0;
      t_proto[i] = 0; t_gw[i] = 0; t_port[i] = 0; t_cost[i] = 0; t_age[i] = 0;
    end
    next_age = AGE_RESET;
  endfunction

  function automatic resp_t route_apply(input req_t r);
    resp_t o;
    logic [31:0] pfx;
    int match, best;
    int unsigned removed;
    o = '0;
    o.status = 1'b1;
    pfx = r.prefix & prefix_mask(r.len);
    best = -1;
    removed = 0;
    case (func_e'(r.func))
      FUNC_ADD, FUNC_DEL: begin
        if (r.len <= 6'd32 && r.proto != PROTO_NONE) begin
          match = -1;
          for (int i = 0; i < NSLOT; i++)
            if (match < 0 && t_valid[i] && t_prefix[i] == pfx && t_len[i] == r.len &&
                t_proto[i] == r.proto) match = i;
          if (r.func == FUNC_ADD) begin
            if (match >= 0) begin
              t_gw[match] = r.gw; t_port[match] = r.port; t_cost[match] = r.cost;
              o.status = 0;
            end else begin
              for (int i = 0; i < NSLOT; i++) begin
                if (!t_valid[i]) begin
                  t_valid[i] = 1; t_prefix[i] = pfx; t_len[i] = r.len;
                  t_proto[i] = r.proto; t_gw[i] = r.gw; t_port[i] = r.port;
                  t_cost[i] = r.cost; t_age[i] = next_age;
                  next_age = next_age + 1;
                  o.status = 0;
                  break;
                end
              end
            end
          end else if (match >= 0) begin
            t_valid[match] = 0; t_chosen[match] = 0;
            o.status = 0;
          end
          if (o.status == 0) elect_routes();
        end
      end
      FUNC_FLUSH: begin
        if (r.proto != PROTO_NONE) begin
          for (int i = 0; i < NSLOT; i++)
            if (t_valid[i] && t_proto[i] == r.proto) begin
              t_valid[i] = 0; t_chosen[i] = 0; removed++;
            end
          elect_routes();
          o.status = 0;
          o.removed = (removed > 63) ? COUNT_SAT : removed[5:0];
        end
      end
      default: begin
        for (int i = 0; i < NSLOT; i++)
          if (t_valid[i] && t_chosen[i] && t_len[i] <= 6'd32 &&
              (r.dst & prefix_mask(t_len[i])) == t_prefix[i])
            if (best < 0 || t_len[i] > t_len[best]) best = i;
        if (best >= 0) begin
          o.status = 0; o.hit = 1; o.gw = t_gw[best]; o.port = t_port[best];
          o.len = t_len[best]; o.cost = t_cost[best]; o.proto = t_proto[best];
        end
      end
    endcase
    return o;
  endfunction

  task automatic report_mismatch(input string what, input resp_t got, input resp_t want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // handshake with sender idling; valid drops only while idling
  task automatic send_req(input req_t r, input logic known, input resp_t want);
    resp_t pred;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= r.func; route_prefix_i <= r.prefix; route_length_i <= r.len;
    gateway_i <= r.gw; port_index_i <= r.port; route_cost_i <= r.cost;
    source_proto_i <= r.proto; dest_address_i <= r.dst;
    do @(posedge clk_i); while (in_stall_o);
    pred = route_apply(r);
    if (known && pred != want) report_mismatch("directed row", pred, want);
    expected_resps.push_back(pred);
  endtask

  function automatic req_t rand_req(input int pool_mode);
    req_t r;
    logic [31:0] bases[4];
    bases = '{32'h0A00_0000, 32'hC0A8_0100, 32'hAC10_0000, 32'h0000_0000};
    r.func = $urandom_range(3);
    r.gw = $urandom; r.port = $urandom; r.dst = $urandom;
    r.cost = ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    r.proto = ($urandom_range(15) == 0) ? $urandom_range(15) : $urandom_range(1, 8);
    r.len = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(32);
    if (pool_mode != 0) begin
      // small address pool so routes collide, nest and match
      r.prefix = bases[$urandom_range(3)] | ($urandom_range(3) << 6);
      r.len = ($urandom_range(19) == 0) ? $urandom_range(63)
              : 6'(8 * $urandom_range(4) - (($urandom_range(1)) ? 0 : 2));
      if (r.len > 6'd40) r.len = 6'd24;
      if ($urandom_range(3) != 0) r.dst = bases[$urandom_range(3)] | ($urandom & 32'h3FF);
    end else begin
      r.prefix = $urandom;
    end
    return r;
  endfunction

  // receiver side and checking
  always @(posedge clk_i) begin
    resp_t got, want;
    if (out_valid_o && !out_stall_i) begin
      got = '{status_o, hit_o, hit_gateway_o, hit_port_o, hit_length_o, hit_cost_o,
              hit_proto_o, removed_count_o};
      if (expected_resps.size() == 0) begin
        report_mismatch("response with none expected", got, '0);
      end else begin
        want = expected_resps.pop_front();
        if (got != want) report_mismatch("response", got, want);
      end
    end
    out_stall_i <= hold_off || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (stim_done == 0 && rst_ni);
    repeat (3000) @(posedge clk_i);
    hold_off = 1;
    repeat (2000) @(posedge clk_i);
    hold_off = 0;
  end

  localparam resp_t R_ERR = '{status: 1'b1, default: '0};
  localparam resp_t R_OK  = '{status: 1'b0, default: '0};

  row_t dir_rows[$];

  initial begin
    req_t r;
    clear_table();
    // after reset: empty table, rejects, extremes
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_DEL, 32'h0A00_0000, 8, 0, 0, 0, PROTO_STATIC, 0}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_ADD, 32'hFFFF_FFFF, 33, 0, 0, 0, PROTO_STATIC, 0}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_ADD, 32'hFFFF_FFFF, 63, 0, 0, 0, PROTO_STATIC, 0}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 0, 0, 0, PROTO_NONE, 0}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_FLUSH, 0, 0, 0, 0, 0, PROTO_NONE, 0}, 1, R_ERR});
    dir_rows.push_back('{'{FUNC_FLUSH, 0, 0, 0, 0, 0, PROTO_RIP, 0}, 1, R_OK});
    // default route, host route, competing protocols, update in place
    dir_rows.push_back('{'{FUNC_ADD, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF,
                           4'hF, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'hFFFF_FFFF, 32, 32'h1, 1, 0, PROTO_DIRECT, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A01_0203, 8, 32'h2, 2, 5, PROTO_OSPF, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 32'h3, 3, 9, PROTO_BGP, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 32'h4, 4, 9, PROTO_BGP, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 32'h5, 5, 1, PROTO_ISIS, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0A09_0909}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0000_0000}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_DEL, 32'h0A00_0000, 8, 0, 0, 0, PROTO_BGP, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0A00_0001}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 32'h6, 6, 1, PROTO_EIGRP, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_ADD, 32'h0A00_0000, 8, 32'h7, 7, 0, PROTO_RIP, 0}, 1, R_OK});
    dir_rows.push_back('{'{FUNC_FLUSH, 0, 0, 0, 0, 0, PROTO_OSPF, 0}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_LOOKUP, 0, 0, 0, 0, 0, 0, 32'h0A00_0001}, 0, R_OK});
    dir_rows.push_back('{'{FUNC_FLUSH, 0, 0, 0, 0, 0, 4'hF, 0}, 0, R_OK});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].resp);

    // fill the table to capacity, hit the full case, then flush a whole protocol
    for (int i = 0; i < NSLOT + 2; i++) begin
      r = rand_req(0);
      r.func = FUNC_ADD; r.len = 32; r.proto = PROTO_STATIC;
      r.prefix = 32'hC000_0000 + i;
      send_req(r, 0, R_OK);
    end
    r.func = FUNC_FLUSH; r.proto = PROTO_STATIC;
    send_req(r, 0, R_OK);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == 0) begin send_idle = 22; recv_idle = 48; end
      if (n == RANDOM_REQS / 3) begin send_idle = 48; recv_idle = 22; end
      if (n == 2 * RANDOM_REQS / 3) begin send_idle = 0; recv_idle = 0; end
      r = rand_req($urandom_range(9) != 0);
      if ($urandom_range(99) == 0) begin
        r.func = FUNC_FLUSH; r.proto = $urandom_range(1, 8);
      end
      send_req(r, 0, R_OK);
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
    send_idle = 0; recv_idle = 0;
    while (expected_resps.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: route_table_lpm_engine_core.f
hdl/rtlpm_pkg.sv
hdl/rtlpm_ram.sv
hdl/rtlpm_ctrl.sv
hdl/rtlpm_dp.sv
hdl/route_table_lpm_engine_core.sv
verif/route_table_lpm_engine_core_tb.sv
